// ===== rtl/spr_pkg.sv =====
// Shared types and constants for the stream pattern replace block.
package spr_pkg;

    // Configuration port geometry: four 64-bit registers at 8-byte spacing
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    // Width of the length registers
    localparam int LEN_W = 4;

    // Default sizes of pattern and replacement content
    localparam int DEF_MAX_PATTERN_BYTES = 8;
    localparam int DEF_MAX_CONTENT_BYTES = 8;

    // Register indexes
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_CONTENT_BYTES  = 2'd2,
        REG_CONTENT_LENGTH = 2'd3
    } reg_idx_t;

    // Configuration register contents as written
    typedef struct packed {
        logic [63:0]      pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      content_bytes;
        logic [LEN_W-1:0] content_length;
    } cfg_t;

    // Result of the shared compare unit
    typedef struct packed {
        logic prefix_ok;   // held bytes agree with the pattern head
        logic full;        // held count equals pattern length
        logic partial;     // held count below pattern length
    } match_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CONTENT,
        ST_FLUSH,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/spr_cfg.sv =====
// APB-style configuration registers for the stream pattern replace block.
module spr_cfg
    import spr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output cfg_t                  cfg,
    output logic                  wr_pulse
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx      = reg_idx_t'(paddr[4:3]);
    assign wr_pulse = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_pulse)
        begin
            unique case (idx)
                REG_PATTERN_BYTES:  cfg_next.pattern_bytes  = pwdata;
                REG_PATTERN_LENGTH: cfg_next.pattern_length = pwdata[LEN_W-1:0];
                REG_CONTENT_BYTES:  cfg_next.content_bytes  = pwdata;
                REG_CONTENT_LENGTH: cfg_next.content_length = pwdata[LEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_PATTERN_BYTES:  prdata = cfg_reg.pattern_bytes;
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(cfg_reg.pattern_length);
            REG_CONTENT_BYTES:  prdata = cfg_reg.content_bytes;
            REG_CONTENT_LENGTH: prdata = CFG_DATA_W'(cfg_reg.content_length);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/spr_match.sv =====
// Shared compare unit: checks the held bytes against the head of the pattern.
module spr_match
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES
)
(
    input  logic [7:0]                               held [MAX_PATTERN_BYTES],
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   len,
    input  logic [63:0]                              pattern,
    input  logic [LEN_W-1:0]                         plen,
    output match_t                                   res
);

    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);

    logic [MAX_PATTERN_BYTES-1:0] hit;

    // Compare every held position; positions past the count always agree
    for (genvar i = 0; i < MAX_PATTERN_BYTES; i++)
    begin : g_cmp
        assign hit[i] = (LW'(i) >= len) || (held[i] == pattern[8*i +: 8]);
    end

    assign res.prefix_ok = &hit;
    assign res.full      = (LEN_W'(len) == plen);
    assign res.partial   = (LEN_W'(len) < plen);

endmodule

// ===== rtl/stream_pattern_replace.sv =====
// Top level of the stream pattern replace block: sequencer, held bytes, output stage.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  input    | in_valid / in_stall         | data_byte, byte_present, token_end
//  output   | out_valid / out_stall       | out_byte, out_present, out_end
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A word passes through an accept step, scan steps that release held bytes and a step that
// ends the scan, content steps that write the replacement bytes after a match, flush steps
// that release the held bytes at token end plus a step that ends the flush, and a closing
// step that passes on the pending word, with the end mark when the token ends.
// The single byte-compare unit checks the held bytes once per sequencer step.
// Reset clears the sequencer, held count, pending slot and output stage; no sweep.
// A stalled output holds the sequencer at the next step that has to emit.
module stream_pattern_replace
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int MAX_CONTENT_BYTES = DEF_MAX_CONTENT_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  byte_present,
    input  logic                  token_end,
    // output words
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  out_present,
    output logic                  out_end,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CW = $clog2(MAX_CONTENT_BYTES + 1);

    cfg_t             cfg;
    logic             cfg_wr;
    match_t           mres;
    logic [LEN_W-1:0] plen_sat;
    logic [LEN_W-1:0] clen_sat;
    logic [63:0]      content_word;

    state_t           state_reg, state_next;
    logic [LW-1:0]    len_reg, len_next, len_base;
    logic [7:0]       held_reg  [MAX_PATTERN_BYTES];
    logic [7:0]       held_next [MAX_PATTERN_BYTES];
    logic             end_reg, end_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_present_reg, out_present_next;
    logic             out_end_reg, out_end_next;

    logic             slot_free;
    logic             emit_ok;
    logic             emit_req;
    logic [7:0]       emit_byte;
    logic             push;
    logic [7:0]       push_byte;
    logic             push_present;
    logic             push_end;

    assign pready = 1'b1;

    spr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .wr_pulse (cfg_wr)
    );

    // Clamp oversized lengths
    assign plen_sat = (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES)) ?
                      LEN_W'(MAX_PATTERN_BYTES) : cfg.pattern_length;
    assign clen_sat = (cfg.content_length > LEN_W'(MAX_CONTENT_BYTES)) ?
                      LEN_W'(MAX_CONTENT_BYTES) : cfg.content_length;

    spr_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .held    (held_reg),
        .len     (len_reg),
        .pattern (cfg.pattern_bytes),
        .plen    (plen_sat),
        .res     (mres)
    );

    // Select the current replacement byte
    assign content_word = cfg.content_bytes >> {cnt_reg, 3'b000};

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_ok   = !pend_valid_reg || slot_free;
    assign len_base  = cfg_wr ? '0 : len_reg;
    assign in_stall  = (state_reg != ST_IDLE);

    // Sequencer: next state, held bytes and emitted words
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        held_next       = held_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        emit_req        = 1'b0;
        emit_byte       = 8'h00;
        push            = 1'b0;
        push_byte       = 8'h00;
        push_present    = 1'b0;
        push_end        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    len_next = '0;
                end
                if (in_valid)
                begin
                    end_next   = token_end;
                    state_next = ST_SCAN;
                    if (byte_present)
                    begin
                        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                        begin
                            if (len_base == LW'(i))
                            begin
                                held_next[i] = data_byte;
                            end
                        end
                        len_next = LW'(len_base + 1'b1);
                    end
                end
            end

            ST_SCAN:
            begin
                if (len_reg == '0)
                begin
                    state_next = ST_FLUSH;
                end
                else if (mres.prefix_ok && mres.full)
                begin
                    // Whole pattern matched: drop the held bytes, write content
                    len_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONTENT;
                end
                else if (mres.prefix_ok && mres.partial)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    // Release the oldest held byte and check the rest again
                    emit_req  = 1'b1;
                    emit_byte = held_reg[0];
                    if (emit_ok)
                    begin
                        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++)
                        begin
                            held_next[i] = held_reg[i+1];
                        end
                        len_next = LW'(len_reg - 1'b1);
                    end
                end
            end

            ST_CONTENT:
            begin
                if (LEN_W'(cnt_reg) == clen_sat)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_byte = content_word[7:0];
                    if (emit_ok)
                    begin
                        cnt_next = CW'(cnt_reg + 1'b1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (end_reg && (len_reg != '0))
                begin
                    // Token end: release every held byte
                    emit_req  = 1'b1;
                    emit_byte = held_reg[0];
                    if (emit_ok)
                    begin
                        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++)
                        begin
                            held_next[i] = held_reg[i+1];
                        end
                        len_next = LW'(len_reg - 1'b1);
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (end_reg)
                begin
                    // Last word of the token carries the end mark
                    if (slot_free)
                    begin
                        push            = 1'b1;
                        push_byte       = pend_valid_reg ? pend_byte_reg : 8'h00;
                        push_present    = pend_valid_reg;
                        push_end        = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    push            = 1'b1;
                    push_byte       = pend_byte_reg;
                    push_present    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Keep one word pending so the end mark can land on the last one
        if (emit_req && emit_ok)
        begin
            if (pend_valid_reg)
            begin
                push         = 1'b1;
                push_byte    = pend_byte_reg;
                push_present = 1'b1;
                push_end     = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
    end

    // Output stage
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_present_next = out_present_reg;
        out_end_next     = out_end_reg;
        if (push)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = push_byte;
            out_present_next = push_present;
            out_end_next     = push_end;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            end_reg        <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            end_reg        <= end_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held_reg        <= held_next;
        pend_byte_reg   <= pend_byte_next;
        out_byte_reg    <= out_byte_next;
        out_present_reg <= out_present_next;
        out_end_reg     <= out_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_present = out_present_reg;
    assign out_end     = out_end_reg;

endmodule

// ===== rtl/spr_check.sv =====
// Port-level checks for the stream pattern replace block, bound to the top level.
module spr_check
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_present,
    input logic       out_end
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(out_present) && $stable(out_end))
        else $error("stalled output word changed");

    // An end-only word always closes the token
    a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_present |-> out_end)
        else $error("word without a byte lacks the end mark");

    // An end-only word carries a zero byte
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_present |-> out_byte == 8'h00)
        else $error("end-only word has a nonzero byte");

    // Busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

endmodule

bind stream_pattern_replace spr_check u_spr_check (.*);
